### src/pal_pkg.sv
// Shared types, codes and widths for the positional array list engine.
package pal_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W      = 3;
    localparam int POS_W     = 8;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 8;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINAL_WR,
        S_READ_WAIT,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_OUT
    } t_state;

endpackage

### src/pal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/positional_array_list_engine.sv
// Top level of the positional array list engine: sequencer, list RAM and result register.
//
// Ordered list of up to CAPACITY signed 32-bit entries, addressed by 1-based position.
// Input stream (s_axis): tuser carries the operation (insert, remove, read, modify,
// search), tdata carries position and value. Output stream (m_axis): one result per
// item; tuser carries the status, tdata carries read value, found position, count
// and the empty and full flags.
// One item is worked on at a time: s_axis_tready is high only while the engine is
// idle. The time from the input transfer to m_axis_tvalid is set by the walk over the
// list RAM, each entry taking a registered read, then a write or compare: insert moves
// the entries at and past the position up, remove moves those past it down, search
// compares entries until a match or the end of the list, read waits on its RAM read,
// and modify, rejected and unknown operations go straight to the result state. After
// the result is taken, the engine returns to idle before it accepts the next transfer.
// The result stays on m_axis, unchanged, until the receiver takes it; no new item
// is taken meanwhile. Reset clears the entry count and returns to idle; the RAM
// contents are not cleared, since no entry is read before it is written.
module positional_array_list_engine #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // position [7:0], value [39:8]
    input  logic [pal_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation [2:0]
    input  logic [pal_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // read_value [31:0], found_position [39:32], count [47:40], is_empty [48],
    // is_full [49], zero pad [55:50]
    output logic [pal_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [pal_pkg::ST_W-1:0]       o_m_axis_tuser
);

    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_op, n_op;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [ST_W-1:0]  r_status, n_status;
    logic [VAL_W-1:0] r_rdval, n_rdval;
    logic [POS_W-1:0] r_fpos, n_fpos;

    // RAM port signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    // Position and index arithmetic, compared at 9 bits so nothing wraps
    logic [POS_W:0]   w_pos9;
    logic [POS_W:0]   w_cnt9;
    logic [POS_W-1:0] w_pos_m1;
    logic [AW-1:0]    w_pos_addr;
    logic [CW-1:0]    w_idx_m1;
    logic [CW-1:0]    w_idx_p1;
    logic             w_pos_zero;
    logic             w_ins_bad;
    logic             w_pos_bad;
    logic             w_full;
    logic             w_is_ins;
    logic             w_match;
    logic             in_xfer;
    logic             out_xfer;

    assign w_pos9     = {1'b0, r_pos};
    assign w_cnt9     = (POS_W + 1)'(r_count);
    assign w_pos_m1   = r_pos - 8'd1;
    assign w_pos_addr = w_pos_m1[AW-1:0];
    assign w_idx_m1   = r_idx - CW'(1);
    assign w_idx_p1   = r_idx + CW'(1);
    assign w_pos_zero = (r_pos == '0);
    assign w_ins_bad  = w_pos_zero || (w_pos9 > (w_cnt9 + 9'd1));
    assign w_pos_bad  = w_pos_zero || (w_pos9 > w_cnt9);
    assign w_full     = (r_count >= CAP_C);
    assign w_is_ins   = (r_op == OP_INSERT);
    assign w_match    = (ram_rdata == r_val);

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_OUT;
                case (r_op)
                    OP_INSERT: begin
                        if (!w_ins_bad && !w_full) begin
                            // Move entries up only if something sits at or past pos
                            n_state = (w_cnt9 >= w_pos9) ? S_SHIFT_RD : S_FINAL_WR;
                        end
                    end
                    OP_REMOVE: begin
                        if (!w_pos_bad && (w_pos9 < w_cnt9)) begin
                            n_state = S_SHIFT_RD;
                        end
                    end
                    OP_READ: begin
                        if (!w_pos_bad) begin
                            n_state = S_READ_WAIT;
                        end
                    end
                    OP_SEARCH: begin
                        if (r_count != '0) begin
                            n_state = S_SEARCH_RD;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (w_is_ins) begin
                    n_state = ((POS_W + 1)'(w_idx_m1) >= w_pos9) ? S_SHIFT_RD : S_FINAL_WR;
                end else begin
                    n_state = (((POS_W + 1)'(w_idx_p1) + 9'd1) < w_cnt9) ? S_SHIFT_RD : S_OUT;
                end
            end
            S_FINAL_WR:  n_state = S_OUT;
            S_READ_WAIT: n_state = S_OUT;
            S_SEARCH_RD: n_state = S_SEARCH_CMP;
            S_SEARCH_CMP: begin
                if (w_match || (w_idx_p1 >= r_count)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SEARCH_RD;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM control and result fields
    always_comb begin
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_idx     = r_idx;
        n_status  = r_status;
        n_rdval   = r_rdval;
        n_fpos    = r_fpos;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op  = i_s_axis_tuser;
                    n_pos = i_s_axis_tdata[POS_W-1:0];
                    n_val = i_s_axis_tdata[POS_W +: VAL_W];
                end
            end
            S_CHECK: begin
                n_status = ST_OK;
                n_rdval  = '0;
                n_fpos   = '0;
                case (r_op)
                    OP_INSERT: begin
                        if (w_ins_bad) begin
                            n_status = ST_BADPOS;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx = r_count;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_pos_bad) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_idx = w_pos_m1[CW-1:0];
                            // Removing the last entry needs no move
                            if (w_pos9 >= w_cnt9) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    OP_READ: begin
                        if (w_pos_bad) begin
                            n_status = ST_BADPOS;
                            n_rdval  = '1;
                        end else begin
                            ram_raddr = w_pos_addr;
                        end
                    end
                    OP_MODIFY: begin
                        if (w_pos_bad) begin
                            n_status = ST_BADPOS;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = w_pos_addr;
                            ram_wdata = r_val;
                        end
                    end
                    OP_SEARCH: begin
                        n_status = ST_NOTFOUND;
                        n_idx    = '0;
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_SHIFT_RD: begin
                ram_raddr = w_is_ins ? w_idx_m1[AW-1:0] : w_idx_p1[AW-1:0];
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = ram_rdata;
                if (w_is_ins) begin
                    n_idx = w_idx_m1;
                end else begin
                    n_idx = w_idx_p1;
                    if (((POS_W + 1)'(w_idx_p1) + 9'd1) >= w_cnt9) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_FINAL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = w_pos_addr;
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
            end
            S_READ_WAIT: begin
                n_rdval = ram_rdata;
            end
            S_SEARCH_RD: begin
                ram_raddr = r_idx[AW-1:0];
            end
            S_SEARCH_CMP: begin
                if (w_match) begin
                    n_status = ST_OK;
                    n_fpos   = POS_W'(w_idx_p1);
                end else begin
                    n_idx = w_idx_p1;
                end
            end
            S_OUT: begin
                // hold the result until the receiver takes it
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rdval  <= n_rdval;
        r_fpos   <= n_fpos;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {6'b0, w_full, (r_count == '0), CNT_OUT_W'(r_count),
                              r_fpos, r_rdval};

endmodule

### src/pal_checker.sv
// Port-level checker for the positional array list engine, bound to the top level.
module pal_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [pal_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [pal_pkg::ST_W-1:0]       o_m_axis_tuser
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an input transfer");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[48] && o_m_axis_tdata[49]))
        else $error("empty and full both set");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind positional_array_list_engine pal_checker u_pal_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
